/* design/mctm_pkg.sv */
// Package for the MIDI clock transport master: event codes, MIDI status bytes,
// output slot codes and the record that travels from the front end to the back end.
// No dependencies.
package mctm_pkg;

    // event codes on the mode field
    localparam logic [2:0] MODE_TICK      = 3'd0;
    localparam logic [2:0] MODE_PLAY      = 3'd1;
    localparam logic [2:0] MODE_STOP      = 3'd2;
    localparam logic [2:0] MODE_PAUSE     = 3'd3;
    localparam logic [2:0] MODE_REWIND    = 3'd4;
    localparam logic [2:0] MODE_FORWARD   = 3'd5;
    localparam logic [2:0] MODE_PORT_PLAY = 3'd6;
    localparam logic [2:0] MODE_PORT_STOP = 3'd7;

    // MIDI real-time and system common bytes
    localparam logic [7:0] MIDI_START    = 8'hfa;
    localparam logic [7:0] MIDI_CONTINUE = 8'hfb;
    localparam logic [7:0] MIDI_STOP     = 8'hfc;
    localparam logic [7:0] MIDI_CLOCK    = 8'hf8;
    localparam logic [7:0] MIDI_SONG_POS = 8'hf2;

    // output slots, sent lowest first
    localparam int SLOT_COUNT = 9;
    localparam logic [3:0] SLOT_POS     = 4'd0;
    localparam logic [3:0] SLOT_POS_LO  = 4'd1;
    localparam logic [3:0] SLOT_POS_HI  = 4'd2;
    localparam logic [3:0] SLOT_START   = 4'd3;
    localparam logic [3:0] SLOT_CONT    = 4'd4;
    localparam logic [3:0] SLOT_STOP    = 4'd5;
    localparam logic [3:0] SLOT_SYNC_SP = 4'd6;
    localparam logic [3:0] SLOT_SYNC_ST = 4'd7;
    localparam logic [3:0] SLOT_CLOCK   = 4'd8;

    // bytes caused by one event; a zero sync mask means no sync byte
    typedef struct packed {
        logic       pos_en;
        logic [6:0] pos_lo;
        logic [6:0] pos_hi;
        logic       start_en;
        logic       cont_en;
        logic       stop_en;
        logic [7:0] ext_mask;
        logic [7:0] sync_stop_mask;
        logic [7:0] sync_start_mask;
        logic       clock_en;
        logic [7:0] clock_mask;
    } rec_t;

endpackage

/* design/mctm_front.sv */
// Front end: accepts events, keeps the transport and meter state and builds one
// byte record per event. Depends on mctm_pkg.
module mctm_front #(
    parameter int CLOCKS_PER_BEAT   = 24,
    parameter int BEATS_PER_MEASURE = 4,
    parameter int PORT_COUNT        = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          in_valid,
    input  logic [2:0]    mode,
    input  logic [2:0]    port_index,
    input  logic          q_full,
    output logic          push,
    output mctm_pkg::rec_t push_rec
);
    import mctm_pkg::*;

    localparam int CBW = $clog2(CLOCKS_PER_BEAT);
    localparam int BW  = $clog2(BEATS_PER_MEASURE);
    localparam logic [7:0] ALL_PORTS = 8'((9'd1 << PORT_COUNT) - 9'd1);

    logic          multi_enable_reg;
    logic          running_reg, running_next;
    logic          paused_reg, paused_next;
    logic          start_pend_reg, start_pend_next;
    logic          cont_pend_reg, cont_pend_next;
    logic          stop_pend_reg, stop_pend_next;
    logic [CBW-1:0] cib_reg, cib_next;
    logic [BW-1:0] beat_reg, beat_next;
    logic [7:0]    measure_reg, measure_next;
    logic [7:0]    pcm_reg, pcm_next;
    logic [7:0]    sync_start_reg, sync_start_next;
    logic [7:0]    sync_stop_reg, sync_stop_next;

    logic          accept;
    logic          count;
    logic [CBW:0]  cib_inc;
    logic [BW:0]   beat_inc;
    logic [7:0]    port_bit;
    logic [7:0]    ext_all;
    logic [11:0]   pos;
    rec_t          rec;

    assign accept   = in_valid & ~q_full;
    assign cib_inc  = {1'b0, cib_reg} + {{CBW{1'b0}}, 1'b1};
    assign beat_inc = {1'b0, beat_reg} + {{BW{1'b0}}, 1'b1};
    assign port_bit = ({1'b0, port_index} < 4'(PORT_COUNT)) ? (8'd1 << port_index) : 8'h00;
    assign ext_all  = multi_enable_reg ? ALL_PORTS : 8'h00;
    // position goes out with the meter as left by the command
    assign pos      = {measure_next, 4'b0000} | (12'(beat_next) << 2);

    always_comb
    begin
        running_next    = running_reg;
        paused_next     = paused_reg;
        start_pend_next = start_pend_reg;
        cont_pend_next  = cont_pend_reg;
        stop_pend_next  = stop_pend_reg;
        cib_next        = cib_reg;
        beat_next       = beat_reg;
        measure_next    = measure_reg;
        pcm_next        = pcm_reg;
        sync_start_next = sync_start_reg;
        sync_stop_next  = sync_stop_reg;
        count           = 1'b0;
        rec             = '0;
        rec.ext_mask    = ext_all;

        case (mode)
            MODE_TICK:
            begin
                count = running_reg & ~paused_reg;
                if (start_pend_reg)
                begin
                    start_pend_next = 1'b0;
                    rec.start_en    = 1'b1;
                    running_next    = 1'b1;
                end
                if (cont_pend_reg)
                begin
                    cont_pend_next = 1'b0;
                    rec.cont_en    = 1'b1;
                    paused_next    = 1'b0;
                end
                if (stop_pend_reg)
                begin
                    stop_pend_next = 1'b0;
                    rec.stop_en    = 1'b1;
                    running_next   = 1'b0;
                    paused_next    = 1'b0;
                    count          = 1'b0;
                end
                if (count)
                begin
                    cib_next = cib_inc[CBW-1:0];
                    if (cib_inc >= (CBW+1)'(CLOCKS_PER_BEAT))
                    begin
                        cib_next = '0;
                        // beat boundary: synched port stops, then starts
                        if (multi_enable_reg)
                        begin
                            if (sync_stop_reg != 8'h00)
                            begin
                                rec.sync_stop_mask = sync_stop_reg;
                                pcm_next           = pcm_next & ~sync_stop_reg;
                                sync_stop_next     = 8'h00;
                            end
                            if (sync_start_reg != 8'h00)
                            begin
                                rec.sync_start_mask = sync_start_reg;
                                pcm_next            = pcm_next | sync_start_reg;
                                sync_start_next     = 8'h00;
                            end
                        end
                        beat_next = beat_inc[BW-1:0];
                        if (beat_inc >= (BW+1)'(BEATS_PER_MEASURE))
                        begin
                            beat_next    = '0;
                            measure_next = measure_reg + 8'd1;
                        end
                    end
                    rec.clock_en   = 1'b1;
                    rec.clock_mask = multi_enable_reg ? (pcm_next & ALL_PORTS) : 8'h00;
                end
            end
            MODE_PLAY:
            begin
                cib_next        = '0;
                beat_next       = '0;
                measure_next    = 8'h00;
                rec.pos_en      = 1'b1;
                start_pend_next = 1'b1;
            end
            MODE_STOP:
            begin
                if (!running_reg)
                begin
                    cib_next     = '0;
                    beat_next    = '0;
                    measure_next = 8'h00;
                    rec.pos_en   = 1'b1;
                end
                stop_pend_next = 1'b1;
            end
            MODE_PAUSE:
            begin
                if (running_reg)
                begin
                    if (paused_reg)
                        cont_pend_next = 1'b1;
                    else
                        paused_next = 1'b1;
                end
                else
                begin
                    paused_next = ~paused_reg;
                end
            end
            MODE_REWIND:
            begin
                if (measure_reg != 8'h00)
                    measure_next = measure_reg - 8'd1;
                cib_next   = '0;
                beat_next  = '0;
                rec.pos_en = 1'b1;
            end
            MODE_FORWARD:
            begin
                measure_next = measure_reg + 8'd1;
                cib_next     = '0;
                beat_next    = '0;
                rec.pos_en   = 1'b1;
            end
            MODE_PORT_PLAY:
            begin
                sync_start_next = sync_start_reg | port_bit;
                sync_stop_next  = sync_stop_reg & ~port_bit;
            end
            default:
            begin
                sync_stop_next  = sync_stop_reg | port_bit;
                sync_start_next = sync_start_reg & ~port_bit;
            end
        endcase
    end

    always_comb
    begin
        push_rec        = rec;
        push_rec.pos_lo = pos[6:0];
        push_rec.pos_hi = {2'b00, pos[11:7]};
    end

    assign push     = accept & (rec.pos_en | rec.start_en | rec.cont_en | rec.stop_en |
                                (rec.sync_stop_mask != 8'h00) |
                                (rec.sync_start_mask != 8'h00) | rec.clock_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multi_enable_reg <= 1'b1;
            running_reg      <= 1'b0;
            paused_reg       <= 1'b0;
            start_pend_reg   <= 1'b0;
            cont_pend_reg    <= 1'b0;
            stop_pend_reg    <= 1'b0;
            cib_reg          <= '0;
            beat_reg         <= '0;
            measure_reg      <= 8'h00;
            pcm_reg          <= ALL_PORTS;
            sync_start_reg   <= 8'h00;
            sync_stop_reg    <= 8'h00;
        end
        else
        begin
            if (cfg_valid)
                multi_enable_reg <= cfg_data;
            if (accept)
            begin
                running_reg    <= running_next;
                paused_reg     <= paused_next;
                start_pend_reg <= start_pend_next;
                cont_pend_reg  <= cont_pend_next;
                stop_pend_reg  <= stop_pend_next;
                cib_reg        <= cib_next;
                beat_reg       <= beat_next;
                measure_reg    <= measure_next;
                pcm_reg        <= pcm_next;
                sync_start_reg <= sync_start_next;
                sync_stop_reg  <= sync_stop_next;
            end
        end
    end

endmodule

/* design/mctm_fifo.sv */
// Two-entry record queue between the front end and the back end.
// Depends on mctm_pkg.
module mctm_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mctm_pkg::rec_t push_rec,
    output logic           full,
    output logic           head_valid,
    output mctm_pkg::rec_t head_rec,
    input  logic           pop
);
    import mctm_pkg::*;

    rec_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_pop;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_rec   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* design/mctm_back.sv */
// Back end: expands one record into its MIDI bytes, one word per cycle while out_stall
// is low, into the output register. Depends on mctm_pkg.
module mctm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  mctm_pkg::rec_t head_rec,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     midi_byte,
    output logic           to_main,
    output logic [7:0]     port_mask,
    output logic           last
);
    import mctm_pkg::*;

    rec_t                  rec_reg, rec_next;
    logic [SLOT_COUNT-1:0] work_reg, work_next;
    logic [SLOT_COUNT-1:0] work_left;
    logic [SLOT_COUNT-1:0] head_slots;
    logic                  out_valid_reg;
    logic [7:0]            byte_reg;
    logic                  main_reg;
    logic [7:0]            mask_reg;
    logic                  last_reg;
    logic                  advance;
    logic [3:0]            sel;
    logic [7:0]            sel_byte;
    logic                  sel_main;
    logic [7:0]            sel_mask;

    assign advance = (work_reg != '0) & (~out_valid_reg | ~out_stall);

    // lowest pending slot goes first
    always_comb
    begin
        sel = SLOT_CLOCK;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (work_reg[i])
                sel = 4'(i);
    end

    always_comb
    begin
        sel_main = 1'b1;
        sel_mask = rec_reg.ext_mask;
        case (sel)
            SLOT_POS:
            begin
                sel_byte = MIDI_SONG_POS;
                sel_mask = 8'h00;
            end
            SLOT_POS_LO:
            begin
                sel_byte = {1'b0, rec_reg.pos_lo};
                sel_mask = 8'h00;
            end
            SLOT_POS_HI:
            begin
                sel_byte = {1'b0, rec_reg.pos_hi};
                sel_mask = 8'h00;
            end
            SLOT_START:   sel_byte = MIDI_START;
            SLOT_CONT:    sel_byte = MIDI_CONTINUE;
            SLOT_STOP:    sel_byte = MIDI_STOP;
            SLOT_SYNC_SP:
            begin
                sel_byte = MIDI_STOP;
                sel_main = 1'b0;
                sel_mask = rec_reg.sync_stop_mask;
            end
            SLOT_SYNC_ST:
            begin
                sel_byte = MIDI_CONTINUE;
                sel_main = 1'b0;
                sel_mask = rec_reg.sync_start_mask;
            end
            default:
            begin
                sel_byte = MIDI_CLOCK;
                sel_mask = rec_reg.clock_mask;
            end
        endcase
    end

    assign head_slots = {head_rec.clock_en,
                         head_rec.sync_start_mask != 8'h00,
                         head_rec.sync_stop_mask != 8'h00,
                         head_rec.stop_en, head_rec.cont_en, head_rec.start_en,
                         {3{head_rec.pos_en}}};

    always_comb
    begin
        work_left = work_reg;
        if (advance)
            work_left[sel] = 1'b0;
        // refill as the last word of a record leaves
        pop       = head_valid & (work_left == '0);
        work_next = pop ? head_slots : work_left;
        rec_next  = pop ? head_rec : rec_reg;
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (advance)
        begin
            byte_reg <= sel_byte;
            main_reg <= sel_main;
            mask_reg <= sel_mask;
            last_reg <= (work_left == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            work_reg <= work_next;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= advance;
        end
    end

    assign out_valid = out_valid_reg;
    assign midi_byte = byte_reg;
    assign to_main   = main_reg;
    assign port_mask = mask_reg;
    assign last      = last_reg;

endmodule

/* design/midi_clock_transport_master_unit.sv */
// Top level of the MIDI clock transport master: front end, record queue, back end.
// Depends on mctm_pkg, mctm_front, mctm_fifo and mctm_back.
//
//   channel  | handshake             | words
//   ---------+-----------------------+--------------------------------------
//   cfg      | cfg_valid / cfg_ready | cfg_data (multi_enable)
//   in       | in_valid / in_stall   | mode, port_index
//   out      | out_valid / out_stall | midi_byte, to_main, port_mask, last
//
// An event is taken while in_stall is low and its state change is done at that edge;
// in_stall rises only when the two-entry record queue is full.
// The back end sends one byte per cycle while out_stall is low; an event gives 1 to 5
// bytes, each registered after its record moves into the back end's work register.
// Events without bytes (pause, port commands, idle ticks) push no record into the queue.
// Reset sets multi_enable and all port clocks on, transport stopped, meter zero.
module midi_clock_transport_master_unit #(
    parameter int CLOCKS_PER_BEAT   = 24,
    parameter int BEATS_PER_MEASURE = 4,
    parameter int PORT_COUNT        = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [2:0] port_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] midi_byte,
    output logic       to_main,
    output logic [7:0] port_mask,
    output logic       last
);
    import mctm_pkg::*;

    logic q_full;
    logic push;
    rec_t push_rec;
    logic head_valid;
    rec_t head_rec;
    logic pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    mctm_front #(
        .CLOCKS_PER_BEAT   (CLOCKS_PER_BEAT),
        .BEATS_PER_MEASURE (BEATS_PER_MEASURE),
        .PORT_COUNT        (PORT_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .mode       (mode),
        .port_index (port_index),
        .q_full     (q_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    mctm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop)
    );

    mctm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .midi_byte  (midi_byte),
        .to_main    (to_main),
        .port_mask  (port_mask),
        .last       (last)
    );

endmodule

/* tb/sv/midi_clock_transport_master_unit_test.sv */
// Testbench for midi_clock_transport_master_unit: a directed transport table, then random
// play/tick runs with multi_enable on, off, then on again, every output word checked in order.
// Depends on mctm_pkg and the design files under design/.
module midi_clock_transport_master_unit_test;
    import mctm_pkg::*;

    localparam int CLOCKS_PER_BEAT   = 24;
    localparam int BEATS_PER_MEASURE = 4;
    localparam int QUIET_LIMIT       = 2000;
    localparam int PLAN_LEN          = 25;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       to_main;
        logic [7:0] port_mask;
        logic       last;
    } midi_word_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] port;
        logic       typed;
        logic       has_word;
        midi_word_t word;
    } plan_row_t;

    localparam midi_word_t NO_WORD = '0;

    // typed rows carry their own expectation, the rest use the transport model
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{MODE_TICK,      3'd0, 1'b1, 1'b0, NO_WORD},    // idle tick sends nothing
        '{MODE_PAUSE,     3'd7, 1'b1, 1'b0, NO_WORD},    // pause toggles while stopped
        '{MODE_PAUSE,     3'd0, 1'b1, 1'b0, NO_WORD},
        '{MODE_PORT_STOP, 3'd0, 1'b1, 1'b0, NO_WORD},
        '{MODE_PORT_PLAY, 3'd7, 1'b1, 1'b0, NO_WORD},
        '{MODE_PORT_PLAY, 3'd5, 1'b1, 1'b0, NO_WORD},
        '{MODE_PORT_STOP, 3'd5, 1'b1, 1'b0, NO_WORD},    // drops the start on port 5
        '{MODE_REWIND,    3'd0, 1'b0, 1'b0, NO_WORD},    // rewind at measure zero
        '{MODE_FORWARD,   3'd2, 1'b0, 1'b0, NO_WORD},
        '{MODE_STOP,      3'd0, 1'b0, 1'b0, NO_WORD},    // stop while stopped
        '{MODE_TICK,      3'd0, 1'b1, 1'b1, '{MIDI_STOP, 1'b1, 8'hff, 1'b1}},
        '{MODE_PLAY,      3'd7, 1'b0, 1'b0, NO_WORD},
        '{MODE_TICK,      3'd1, 1'b1, 1'b1, '{MIDI_START, 1'b1, 8'hff, 1'b1}},
        '{MODE_TICK,      3'd6, 1'b1, 1'b1, '{MIDI_CLOCK, 1'b1, 8'hff, 1'b1}},
        '{MODE_PAUSE,     3'd3, 1'b1, 1'b0, NO_WORD},
        '{MODE_TICK,      3'd4, 1'b1, 1'b0, NO_WORD},    // paused: no clock
        '{MODE_PAUSE,     3'd2, 1'b1, 1'b0, NO_WORD},    // second pause asks to continue
        '{MODE_TICK,      3'd1, 1'b1, 1'b1, '{MIDI_CONTINUE, 1'b1, 8'hff, 1'b1}},
        '{MODE_STOP,      3'd1, 1'b1, 1'b0, NO_WORD},    // stop while running waits for a tick
        '{MODE_TICK,      3'd1, 1'b1, 1'b1, '{MIDI_STOP, 1'b1, 8'hff, 1'b1}},
        '{MODE_PAUSE,     3'd1, 1'b1, 1'b0, NO_WORD},
        '{MODE_PLAY,      3'd0, 1'b0, 1'b0, NO_WORD},    // play while paused and stopped
        '{MODE_TICK,      3'd1, 1'b1, 1'b1, '{MIDI_START, 1'b1, 8'hff, 1'b1}},
        '{MODE_TICK,      3'd1, 1'b1, 1'b0, NO_WORD},    // pause survived the start
        '{MODE_PAUSE,     3'd1, 1'b1, 1'b0, NO_WORD}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] mode;
    logic [2:0] port_index;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] midi_byte;
    logic       to_main;
    logic [7:0] port_mask;
    logic       last;

    // transport model state
    logic       ext_enabled;
    logic       running;
    logic       paused;
    logic       start_want;
    logic       cont_want;
    logic       stop_want;
    logic [4:0] clk_in_beat;
    logic [1:0] beat_no;
    logic [7:0] measure_no;
    logic [7:0] clock_ports;
    logic [7:0] sync_start;
    logic [7:0] sync_stop;

    midi_word_t event_words[$];
    midi_word_t due_words[$];
    midi_word_t want_word;

    int err_count     = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int beat_edges    = 0;
    int sync_words    = 0;
    int quiet_cycles  = 0;
    int sink_hold     = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    midi_clock_transport_master_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .port_index (port_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .midi_byte  (midi_byte),
        .to_main    (to_main),
        .port_mask  (port_mask),
        .last       (last)
    );

    always #6 clk = ~clk;

    function automatic void reset_transport();
        ext_enabled = 1'b1;
        running     = 1'b0;
        paused      = 1'b0;
        start_want  = 1'b0;
        cont_want   = 1'b0;
        stop_want   = 1'b0;
        clk_in_beat = '0;
        beat_no     = '0;
        measure_no  = '0;
        clock_ports = 8'hff;
        sync_start  = '0;
        sync_stop   = '0;
    endfunction

    function automatic logic [7:0] ext_ports(input logic [7:0] mask);
        return ext_enabled ? mask : 8'h00;
    endfunction

    function automatic void put_word(input logic [7:0] b, input logic main_out,
                                     input logic [7:0] mask);
        midi_word_t w;
        w.midi_byte = b;
        w.to_main   = main_out;
        w.port_mask = mask;
        w.last      = 1'b0;
        event_words.push_back(w);
    endfunction

    function automatic void put_position();
        logic [15:0] pos;
        pos = ({14'd0, beat_no} << 2) | ({8'd0, measure_no} << 4);
        put_word(MIDI_SONG_POS, 1'b1, 8'h00);
        put_word({1'b0, pos[6:0]}, 1'b1, 8'h00);
        put_word({1'b0, pos[13:7]}, 1'b1, 8'h00);
    endfunction

    // Works out the words one event causes and advances the transport state.
    function automatic void transport_event(input logic [2:0] m, input logic [2:0] p);
        logic [7:0] pbit;
        logic       counts;
        event_words.delete();
        pbit = 8'd1 << p;
        case (m)
            MODE_TICK:
            begin
                // decided before the pending requests are served
                counts = running && !paused;
                if (start_want)
                begin
                    start_want = 1'b0;
                    put_word(MIDI_START, 1'b1, ext_ports(8'hff));
                    running = 1'b1;
                end
                if (cont_want)
                begin
                    cont_want = 1'b0;
                    put_word(MIDI_CONTINUE, 1'b1, ext_ports(8'hff));
                    paused = 1'b0;
                end
                if (stop_want)
                begin
                    stop_want = 1'b0;
                    put_word(MIDI_STOP, 1'b1, ext_ports(8'hff));
                    running = 1'b0;
                    paused  = 1'b0;
                    counts  = 1'b0;
                end
                if (counts)
                begin
                    if (clk_in_beat == CLOCKS_PER_BEAT - 1)
                    begin
                        clk_in_beat = '0;
                        beat_edges++;
                        if (ext_enabled)
                        begin
                            if (sync_stop != 0)
                            begin
                                put_word(MIDI_STOP, 1'b0, sync_stop);
                                clock_ports &= ~sync_stop;
                                sync_stop = '0;
                                sync_words++;
                            end
                            if (sync_start != 0)
                            begin
                                put_word(MIDI_CONTINUE, 1'b0, sync_start);
                                clock_ports |= sync_start;
                                sync_start = '0;
                                sync_words++;
                            end
                        end
                        if (beat_no == BEATS_PER_MEASURE - 1)
                        begin
                            beat_no = '0;
                            measure_no = measure_no + 8'd1;
                        end
                        else
                            beat_no = beat_no + 2'd1;
                    end
                    else
                        clk_in_beat = clk_in_beat + 5'd1;
                    put_word(MIDI_CLOCK, 1'b1, ext_ports(clock_ports));
                end
            end
            MODE_PLAY:
            begin
                clk_in_beat = '0;
                beat_no     = '0;
                measure_no  = '0;
                put_position();
                start_want = 1'b1;
            end
            MODE_STOP:
            begin
                if (!running)
                begin
                    clk_in_beat = '0;
                    beat_no     = '0;
                    measure_no  = '0;
                    put_position();
                end
                stop_want = 1'b1;
            end
            MODE_PAUSE:
            begin
                if (running)
                begin
                    if (paused)
                        cont_want = 1'b1;
                    else
                        paused = 1'b1;
                end
                else
                    paused = !paused;
            end
            MODE_REWIND:
            begin
                if (measure_no != 0)
                    measure_no = measure_no - 8'd1;
                clk_in_beat = '0;
                beat_no     = '0;
                put_position();
            end
            MODE_FORWARD:
            begin
                measure_no  = measure_no + 8'd1;
                clk_in_beat = '0;
                beat_no     = '0;
                put_position();
            end
            MODE_PORT_PLAY:
            begin
                sync_start |= pbit;
                sync_stop  &= ~pbit;
            end
            default:
            begin
                sync_stop  |= pbit;
                sync_start &= ~pbit;
            end
        endcase
        if (event_words.size() != 0)
            event_words[event_words.size() - 1].last = 1'b1;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] seen,
                                   input logic [7:0] wanted);
        if (err_count < 40)
            $display("MISMATCH %s: got %02h expected %02h at %0t", what, seen, wanted, $time);
        err_count++;
    endtask

    // Called at a clock edge; returns at the edge where the word is taken.
    task automatic push_event(input logic [2:0] m, input logic [2:0] p, input logic typed,
                              input logic has_word, input midi_word_t word);
        int gap;
        gap = ($urandom_range(0, 99) < src_idle_pct) ? burst_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        port_index <= p;
        do @(posedge clk); while (in_stall);
        transport_event(m, p);
        if (typed)
        begin
            if (has_word)
                due_words.push_back(word);
        end
        else
            foreach (event_words[i])
                due_words.push_back(event_words[i]);
        items_sent++;
    endtask

    task automatic push_random(input logic [2:0] m);
        push_event(m, 3'($urandom_range(0, 7)), 1'b0, 1'b0, NO_WORD);
    endtask

    task automatic write_multi_enable(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        ext_enabled = v;
    endtask

    // wait for every expected word, then let idle events finish
    task automatic settle();
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Play, a run of ticks with scattered commands, stop; now and then a burst of noise.
    task automatic run_phase(input int items, input int fwd_pct);
        int         done;
        int         runlen;
        int         r;
        logic [2:0] m;
        done = 0;
        while (done < items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                push_random(MODE_PLAY);
                push_random(MODE_TICK);
                runlen = $urandom_range(10, 70);
                repeat (runlen)
                begin
                    r = $urandom_range(0, 99);
                    if (r < fwd_pct)
                        m = MODE_FORWARD;
                    else if (r < fwd_pct + 3)
                        m = MODE_REWIND;
                    else if (r < fwd_pct + 6)
                        m = MODE_PAUSE;
                    else if (r < fwd_pct + 12)
                        m = $urandom_range(0, 1) ? MODE_PORT_PLAY : MODE_PORT_STOP;
                    else
                        m = MODE_TICK;
                    push_random(m);
                end
                push_random(MODE_STOP);
                push_random(MODE_TICK);
                done += runlen + 4;
            end
            else
            begin
                runlen = $urandom_range(1, 6);
                repeat (runlen)
                    push_random(3'($urandom_range(0, 7)));
                done += runlen;
            end
        end
    endtask

    // output side stall pattern
    always @(posedge clk)
    begin
        if (sink_hold != 0)
            sink_hold--;
        else
        begin
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
            sink_hold = burst_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_words.size() == 0)
                report_mismatch("word with nothing expected", midi_byte, 8'h00);
            else
            begin
                want_word = due_words.pop_front();
                words_checked++;
                if (midi_byte !== want_word.midi_byte)
                    report_mismatch("midi_byte", midi_byte, want_word.midi_byte);
                if (to_main !== want_word.to_main)
                    report_mismatch("to_main", {7'd0, to_main}, {7'd0, want_word.to_main});
                if (port_mask !== want_word.port_mask)
                    report_mismatch("port_mask", port_mask, want_word.port_mask);
                if (last !== want_word.last)
                    report_mismatch("last", {7'd0, last}, {7'd0, want_word.last});
            end
        end
    end

    // watchdog: cycles in which no channel moves a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout with %0d words still expected", due_words.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= 1'b0;
        in_valid   <= 1'b0;
        mode       <= MODE_TICK;
        port_index <= 3'd0;
        out_stall  <= 1'b0;
        reset_transport();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_multi_enable(1'b1);
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        for (int i = 0; i < PLAN_LEN; i++)
            push_event(PLAN[i].mode, PLAN[i].port, PLAN[i].typed, PLAN[i].has_word,
                       PLAN[i].word);

        src_idle_pct  = 30;
        sink_idle_pct = 30;
        run_phase(160, 2);
        settle();

        // extra outputs off, no idling on either side
        write_multi_enable(1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(90, 3);
        settle();

        // back on, forward-heavy so the position high byte moves
        write_multi_enable(1'b1);
        src_idle_pct  = 50;
        sink_idle_pct = 60;
        run_phase(120, 20);
        settle();

        $display("Checked %0d words from %0d events, extra outputs on, off, then on again.",
                 words_checked, items_sent);
        $display("Model crossed %0d beat boundaries and sent %0d synched port words.",
                 beat_edges, sync_words);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
